// ===== src/hppc_pkg.sv =====
package hppc_pkg;

  localparam int TACH_WIDTH = 24;

  // control-law datapath widths
  localparam int POS_W  = (TACH_WIDTH > 16) ? TACH_WIDTH : 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = 16 + DIFF_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // setpoint mapping: (sp + 1000) * span, then / 2000 toward zero
  localparam int SPAN_W      = 17;
  localparam int OFFSET_W    = 11;
  localparam int SPAN_PROD_W = OFFSET_W + 1 + SPAN_W;
  localparam int SPAN_MAG_W  = SPAN_PROD_W - 1;
  localparam int DIV_PRESHIFT = 4;                     // 2000 = 16 * 125
  localparam int DIV_Y_W      = SPAN_MAG_W - DIV_PRESHIFT;
  localparam int DIV_RECIP_W  = 25;
  localparam int DIV_SHIFT    = 31;
  localparam int DIV_PROD_W   = DIV_Y_W + DIV_RECIP_W;
  localparam int DIV_Q_W      = DIV_PROD_W - DIV_SHIFT;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 25'd17179870; // ceil(2^31 / 125)

  localparam logic signed [15:0] SP_MIN = -16'sd1000;
  localparam logic signed [15:0] SP_MAX = 16'sd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN             = 3'd0,
    REG_MAX_DUTY         = 3'd1,
    REG_SEEK_DUTY        = 3'd2,
    REG_SWITCH_THRESHOLD = 3'd3,
    REG_CENTER_POSITION  = 3'd4,
    REG_LEFT_LIMIT       = 3'd5,
    REG_RIGHT_LIMIT      = 3'd6,
    REG_DEADBAND         = 3'd7
  } reg_idx_t;

  typedef enum logic {
    CMD_TICK       = 1'b0,
    CMD_SET_TARGET = 1'b1
  } cmd_t;

  localparam logic [15:0]        GAIN_RST        = 16'd213;
  localparam logic [14:0]        MAX_DUTY_RST    = 15'd14746;
  localparam logic signed [15:0] SEEK_DUTY_RST   = 16'sd1966;
  localparam logic [11:0]        THRESHOLD_RST   = 12'd3103;
  localparam logic signed [15:0] CENTER_RST      = 16'sd420;
  localparam logic signed [15:0] LEFT_RST        = -16'sd420;
  localparam logic signed [15:0] RIGHT_RST       = 16'sd420;
  localparam logic [15:0]        DEADBAND_RST    = 16'd0;

  typedef struct packed {
    logic [15:0]               gain;
    logic [14:0]               max_duty;
    logic signed [15:0]        seek_duty;
    logic [11:0]               switch_threshold;
    logic signed [15:0]        center_position;
    logic signed [15:0]        left_limit;
    logic signed [15:0]        right_limit;
    logic [15:0]               deadband;
    logic signed [SPAN_W-1:0]  span;
  } cfg_t;

  typedef struct packed {
    logic                          command;
    logic signed [SPAN_PROD_W-1:0] span_prod;
    logic signed [TACH_WIDTH-1:0]  tach;
    logic [11:0]                   switch_adc;
  } s1_t;

endpackage

// ===== src/hppc_cfg_regs.sv =====
module hppc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hppc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hppc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hppc_pkg::cfg_t                  cfg
);
  import hppc_pkg::*;

  logic [15:0]        gain;
  logic [14:0]        max_duty;
  logic signed [15:0] seek_duty;
  logic [11:0]        switch_threshold;
  logic signed [15:0] center_position;
  logic signed [15:0] left_limit;
  logic signed [15:0] right_limit;
  logic [15:0]        deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain             <= GAIN_RST;
      max_duty         <= MAX_DUTY_RST;
      seek_duty        <= SEEK_DUTY_RST;
      switch_threshold <= THRESHOLD_RST;
      center_position  <= CENTER_RST;
      left_limit       <= LEFT_RST;
      right_limit      <= RIGHT_RST;
      deadband         <= DEADBAND_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN:             gain             <= cfg_wdata;
        REG_MAX_DUTY:         max_duty         <= cfg_wdata[14:0];
        REG_SEEK_DUTY:        seek_duty        <= cfg_wdata;
        REG_SWITCH_THRESHOLD: switch_threshold <= cfg_wdata[11:0];
        REG_CENTER_POSITION:  center_position  <= cfg_wdata;
        REG_LEFT_LIMIT:       left_limit       <= cfg_wdata;
        REG_RIGHT_LIMIT:      right_limit      <= cfg_wdata;
        REG_DEADBAND:         deadband         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.gain             = gain;
    cfg.max_duty         = max_duty;
    cfg.seek_duty        = seek_duty;
    cfg.switch_threshold = switch_threshold;
    cfg.center_position  = center_position;
    cfg.left_limit       = left_limit;
    cfg.right_limit      = right_limit;
    cfg.deadband         = deadband;
    cfg.span             = SPAN_W'(right_limit) - SPAN_W'(left_limit);
  end

endmodule

// ===== src/hppc_in_stage.sv =====
module hppc_in_stage (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   command,
  input  logic signed [15:0]                     setpoint,
  input  logic signed [hppc_pkg::TACH_WIDTH-1:0] tach_position,
  input  logic [11:0]                            switch_adc,
  input  logic signed [hppc_pkg::SPAN_W-1:0]     span,
  output logic                                   s1_valid,
  input  logic                                   s1_ready,
  output hppc_pkg::s1_t                          s1
);
  import hppc_pkg::*;

  logic signed [15:0]            sp_clamped;
  logic signed [15:0]            sp_offset;
  logic signed [OFFSET_W:0]      offset_s;
  logic signed [SPAN_PROD_W-1:0] span_prod;

  // clamp, shift into 0..2000 and scale by the limit span
  always_comb begin
    if (setpoint < SP_MIN) begin
      sp_clamped = SP_MIN;
    end else if (setpoint > SP_MAX) begin
      sp_clamped = SP_MAX;
    end else begin
      sp_clamped = setpoint;
    end
    sp_offset = sp_clamped - SP_MIN;
    offset_s  = {1'b0, sp_offset[OFFSET_W-1:0]};
    span_prod = offset_s * span;
  end

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1.command    <= command;
      s1.span_prod  <= span_prod;
      s1.tach       <= tach_position;
      s1.switch_adc <= switch_adc;
    end
  end

endmodule

// ===== src/hppc_exec_stage.sv =====
module hppc_exec_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s1_valid,
  output logic               s1_ready,
  input  hppc_pkg::s1_t      s1,
  input  hppc_pkg::cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] duty,
  output logic               homed,
  output logic               load_tach,
  output logic signed [15:0] tach_load_value,
  output logic signed [15:0] target_now
);
  import hppc_pkg::*;

  // controller state
  logic               homed_flag;
  logic signed [15:0] target_position;
  logic signed [15:0] duty_hold;

  logic               homed_flag_next;
  logic signed [15:0] target_position_next;
  logic signed [15:0] duty_hold_next;
  logic               load_next;
  logic               fire;

  // setpoint division
  logic                          prod_neg;
  logic [SPAN_PROD_W-1:0]        prod_negated;
  logic [SPAN_MAG_W-1:0]         prod_mag;
  logic [DIV_Y_W-1:0]            div_y;
  logic [DIV_PROD_W-1:0]         div_prod;
  logic [DIV_Q_W-1:0]            div_q;
  logic signed [DIV_Q_W+1:0]     quot_s;
  logic signed [DIV_Q_W+1:0]     new_target;

  // control law
  logic signed [POS_W-1:0]  pos;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_negated;
  logic [DIFF_W-1:0]        err_mag;
  logic                     in_band;
  logic [PROD_W-1:0]        raw_duty;
  logic [14:0]              sat_duty;
  logic signed [15:0]       law_duty;
  logic                     switch_hit;

  assign s1_ready = !out_valid || out_ready;
  assign fire     = s1_valid && s1_ready;

  // divide by 2000 toward zero: magnitude >> 4, then reciprocal of 125
  always_comb begin
    prod_neg     = s1.span_prod[SPAN_PROD_W-1];
    prod_negated = -s1.span_prod;
    prod_mag     = prod_neg ? prod_negated[SPAN_MAG_W-1:0]
                            : s1.span_prod[SPAN_MAG_W-1:0];
    div_y        = prod_mag[SPAN_MAG_W-1:DIV_PRESHIFT];
    div_prod     = DIV_PROD_W'(div_y) * DIV_PROD_W'(DIV_RECIP);
    div_q        = div_prod[DIV_PROD_W-1:DIV_SHIFT];
    quot_s       = prod_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    new_target   = quot_s + (DIV_Q_W+2)'(cfg.left_limit);
  end

  // before homing the position is taken as the center it is about to load
  always_comb begin
    pos          = homed_flag ? POS_W'(s1.tach) : POS_W'(cfg.center_position);
    diff         = DIFF_W'(pos) - DIFF_W'(target_position);
    diff_negated = -diff;
    err_mag      = diff[DIFF_W-1] ? diff_negated : diff;
    in_band      = err_mag <= DIFF_W'(cfg.deadband);
    raw_duty     = PROD_W'(cfg.gain) * PROD_W'(err_mag);
    sat_duty     = (raw_duty > PROD_W'(cfg.max_duty)) ? cfg.max_duty : raw_duty[14:0];
    if (in_band) begin
      law_duty = '0;
    end else if (!diff[DIFF_W-1]) begin
      law_duty = -$signed({1'b0, sat_duty});
    end else begin
      law_duty = $signed({1'b0, sat_duty});
    end
  end

  assign switch_hit = s1.switch_adc >= cfg.switch_threshold;

  always_comb begin
    homed_flag_next      = homed_flag;
    target_position_next = target_position;
    duty_hold_next       = duty_hold;
    load_next            = 1'b0;
    if (s1.command == CMD_SET_TARGET) begin
      target_position_next = new_target[15:0];
    end else if (!homed_flag) begin
      if (switch_hit) begin
        homed_flag_next = 1'b1;
        load_next       = 1'b1;
        duty_hold_next  = law_duty;
      end else begin
        duty_hold_next  = cfg.seek_duty;
      end
    end else begin
      duty_hold_next = law_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      homed_flag      <= 1'b0;
      target_position <= '0;
      duty_hold       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (fire) begin
        homed_flag      <= homed_flag_next;
        target_position <= target_position_next;
        duty_hold       <= duty_hold_next;
      end
      if (s1_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      duty            <= duty_hold_next;
      homed           <= homed_flag_next;
      load_tach       <= load_next;
      tach_load_value <= cfg.center_position;
      target_now      <= target_position_next;
    end
  end

endmodule

// ===== src/homing_position_p_controller.sv =====
// Input transfer to result valid passes an input register, then a result register.
// Throughput: one item per cycle while out_ready is high; one multiply per path sets it.
// Reset (rst, synchronous): not homed, target 0, held duty 0, both stages empty,
// configuration registers back to their defaults.
module homing_position_p_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [hppc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hppc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   command,
  input  logic signed [15:0]                     setpoint,
  input  logic signed [hppc_pkg::TACH_WIDTH-1:0] tach_position,
  input  logic [11:0]                            switch_adc,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [15:0]                     duty,
  output logic                                   homed,
  output logic                                   load_tach,
  output logic signed [15:0]                     tach_load_value,
  output logic signed [15:0]                     target_now
);
  import hppc_pkg::*;

  cfg_t cfg;
  s1_t  s1;
  logic s1_valid;
  logic s1_ready;

  hppc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hppc_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .setpoint      (setpoint),
    .tach_position (tach_position),
    .switch_adc    (switch_adc),
    .span          (cfg.span),
    .s1_valid      (s1_valid),
    .s1_ready      (s1_ready),
    .s1            (s1)
  );

  hppc_exec_stage u_exec_stage (
    .clk             (clk),
    .rst             (rst),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready),
    .s1              (s1),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .duty            (duty),
    .homed           (homed),
    .load_tach       (load_tach),
    .tach_load_value (tach_load_value),
    .target_now      (target_now)
  );

endmodule

// ===== sim/controller_checker.sv =====
`timescale 1ns / 100ps

module controller_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [hppc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hppc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   command,
  input  logic signed [15:0]                     setpoint,
  input  logic signed [hppc_pkg::TACH_WIDTH-1:0] tach_position,
  input  logic [11:0]                            switch_adc,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [15:0]                     duty,
  input  logic                                   homed,
  input  logic                                   load_tach,
  input  logic signed [15:0]                     tach_load_value,
  input  logic signed [15:0]                     target_now,
  output int                                     results_due,
  output int                                     failures
);
  import hppc_pkg::*;

  typedef struct packed {
    logic signed [15:0] duty;
    logic               homed;
    logic               load_tach;
    logic signed [15:0] tach_load_value;
    logic signed [15:0] target_now;
  } ctrl_result_t;

  logic [15:0]        gain_r;
  logic [14:0]        max_duty_r;
  logic signed [15:0] seek_duty_r;
  logic [11:0]        threshold_r;
  logic signed [15:0] center_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  logic [15:0]        deadband_r;

  logic               homed_r;
  logic signed [15:0] target_r;
  logic signed [15:0] duty_r;

  ctrl_result_t expected_q[$];
  int           bad_cnt = 0;

  assign failures = bad_cnt;

  // proportional law on |error|, saturated, signed against the error
  function automatic logic signed [15:0] law_duty(longint pos);
    longint err;
    longint mag;
    longint d;
    err = pos - longint'(target_r);
    mag = (err < 0) ? -err : err;
    if (mag <= longint'(deadband_r)) return '0;
    d = longint'(gain_r) * mag;
    if (d > longint'(max_duty_r)) d = longint'(max_duty_r);
    d = (err > 0) ? -d : d;
    return d[15:0];
  endfunction

  function automatic ctrl_result_t advance(logic cmd, logic signed [15:0] sp_in,
                                           logic signed [TACH_WIDTH-1:0] tach,
                                           logic [11:0] adc);
    ctrl_result_t r;
    longint sp;
    longint t;
    logic load;
    load = 1'b0;
    if (cmd == CMD_SET_TARGET) begin
      sp = longint'(sp_in);
      if (sp < -1000) sp = -1000;
      if (sp > 1000) sp = 1000;
      t = (sp + 1000) * (longint'(right_r) - longint'(left_r)) / 2000 + longint'(left_r);
      target_r = t[15:0];
    end else if (!homed_r) begin
      if (adc >= threshold_r) begin
        homed_r = 1'b1;
        load = 1'b1;
        // tach is about to be loaded with the center value
        duty_r = law_duty(longint'(center_r));
      end else begin
        duty_r = seek_duty_r;
      end
    end else begin
      duty_r = law_duty(longint'(tach));
    end
    r.duty            = duty_r;
    r.homed           = homed_r;
    r.load_tach       = load;
    r.tach_load_value = center_r;
    r.target_now      = target_r;
    return r;
  endfunction

  always @(posedge clk) begin
    ctrl_result_t got;
    ctrl_result_t want;
    if (rst) begin
      gain_r        = GAIN_RST;
      max_duty_r    = MAX_DUTY_RST;
      seek_duty_r   = SEEK_DUTY_RST;
      threshold_r   = THRESHOLD_RST;
      center_r      = CENTER_RST;
      left_r        = LEFT_RST;
      right_r       = RIGHT_RST;
      deadband_r    = DEADBAND_RST;
      homed_r       = 1'b0;
      target_r      = '0;
      duty_r        = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN:             gain_r        = cfg_wdata;
          REG_MAX_DUTY:         max_duty_r    = cfg_wdata[14:0];
          REG_SEEK_DUTY:        seek_duty_r   = cfg_wdata;
          REG_SWITCH_THRESHOLD: threshold_r   = cfg_wdata[11:0];
          REG_CENTER_POSITION:  center_r      = cfg_wdata;
          REG_LEFT_LIMIT:       left_r        = cfg_wdata;
          REG_RIGHT_LIMIT:      right_r       = cfg_wdata;
          REG_DEADBAND:         deadband_r    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(advance(command, setpoint, tach_position, switch_adc));
      if (out_valid && out_ready) begin
        got.duty            = duty;
        got.homed           = homed;
        got.load_tach       = load_tach;
        got.tach_load_value = tach_load_value;
        got.target_now      = target_now;
        if (expected_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("%0t: result transfer with nothing expected: duty %0d target %0d",
                     $realtime, duty, target_now);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display({"%0t: mismatch exp/act duty %0d/%0d homed %0b/%0b load %0b/%0b",
                        " load_value %0d/%0d target %0d/%0d"}, $realtime,
                       want.duty, got.duty, want.homed, got.homed,
                       want.load_tach, got.load_tach,
                       want.tach_load_value, got.tach_load_value,
                       want.target_now, got.target_now);
          end
        end
      end
    end
    results_due <= expected_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import hppc_pkg::*;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         command = CMD_TICK;
  logic signed [15:0]           setpoint = '0;
  logic signed [TACH_WIDTH-1:0] tach_position = '0;
  logic [11:0]                  switch_adc = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [15:0]           duty;
  logic                         homed;
  logic                         load_tach;
  logic signed [15:0]           tach_load_value;
  logic signed [15:0]           target_now;

  int results_due;
  int failures;
  bit gaps_on = 1'b1;

  // limits as last written, used to aim tach readings near the target
  logic signed [15:0] lim_left  = LEFT_RST;
  logic signed [15:0] lim_right = RIGHT_RST;

  homing_position_p_controller u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .setpoint        (setpoint),
    .tach_position   (tach_position),
    .switch_adc      (switch_adc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .duty            (duty),
    .homed           (homed),
    .load_tach       (load_tach),
    .tach_load_value (tach_load_value),
    .target_now      (target_now)
  );

  controller_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .setpoint        (setpoint),
    .tach_position   (tach_position),
    .switch_adc      (switch_adc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .duty            (duty),
    .homed           (homed),
    .load_tach       (load_tach),
    .tach_load_value (tach_load_value),
    .target_now      (target_now),
    .results_due     (results_due),
    .failures        (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == REG_LEFT_LIMIT) lim_left = value;
    if (idx == REG_RIGHT_LIMIT) lim_right = value;
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_item(logic cmd, logic signed [15:0] sp,
                           logic signed [TACH_WIDTH-1:0] tp, logic [11:0] adc);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    setpoint      <= sp;
    tach_position <= tp;
    switch_adc    <= adc;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] pick_value(logic [15:0] ext_a, logic [15:0] ext_b,
                                             logic [15:0] typical);
    case ($urandom_range(0, 7))
      0:       return ext_a;
      1:       return ext_b;
      default: return typical;
    endcase
  endfunction

  task automatic random_config;
    write_reg(REG_GAIN, pick_value(16'h0000, 16'hFFFF, 16'($urandom_range(1, 400))));
    write_reg(REG_MAX_DUTY, pick_value(16'h0000, 16'h7FFF, 16'($urandom_range(0, 32767))));
    write_reg(REG_SEEK_DUTY, pick_value(16'h8000, 16'h7FFF, 16'($urandom)));
    write_reg(REG_SWITCH_THRESHOLD, pick_value(16'h0000, 16'h0FFF,
                                               16'($urandom_range(0, 4095))));
    write_reg(REG_CENTER_POSITION, pick_value(16'h8000, 16'h7FFF, 16'($urandom)));
    write_reg(REG_LEFT_LIMIT, pick_value(16'h8000, 16'h7FFF,
                                         16'(int'($urandom_range(0, 4000)) - 2000)));
    write_reg(REG_RIGHT_LIMIT, pick_value(16'h8000, 16'h7FFF,
                                          16'(int'($urandom_range(0, 4000)) - 2000)));
    write_reg(REG_DEADBAND, pick_value(16'h0000, 16'hFFFF, 16'($urandom_range(0, 30))));
    cfg_we <= 1'b0;
  endtask

  task automatic random_item;
    int lo;
    int hi;
    logic signed [15:0] sp;
    logic signed [TACH_WIDTH-1:0] tp;
    logic cmd;
    lo = (lim_left < lim_right) ? int'(lim_left) : int'(lim_right);
    hi = (lim_left < lim_right) ? int'(lim_right) : int'(lim_left);
    if ($urandom_range(0, 4) == 0) sp = 16'($urandom);
    else sp = 16'(int'($urandom_range(0, 2400)) - 1200);
    if ($urandom_range(0, 5) == 0) tp = TACH_WIDTH'($urandom);
    else tp = TACH_WIDTH'(lo + int'($urandom_range(0, hi - lo))
                          + int'($urandom_range(0, 600)) - 300);
    cmd = ($urandom_range(0, 3) == 0) ? CMD_SET_TARGET : CMD_TICK;
    send_item(cmd, sp, tp, 12'($urandom_range(0, 4095)));
  endtask

  task automatic run_random(int count, bit allow_gaps);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
      random_item();
    end
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // setpoint clamping and mapping with default limits, then homing seek
    send_item(CMD_SET_TARGET, 16'sh8000, '0, '0);
    send_item(CMD_SET_TARGET, 16'sh7FFF, '0, '0);
    send_item(CMD_SET_TARGET, 16'sd999, '0, '0);
    send_item(CMD_SET_TARGET, -16'sd999, '0, '0);
    send_item(CMD_SET_TARGET, 16'sd0, '0, '0);
    send_item(CMD_TICK, '0, 24'sh7FFFFF, 12'd0);
    send_item(CMD_TICK, '0, '0, 12'd3102);

    settle();
    write_reg(REG_SEEK_DUTY, 16'h8000);
    write_reg(REG_SWITCH_THRESHOLD, 16'h0FFF);
    write_reg(REG_CENTER_POSITION, 16'h7FFF);
    write_reg(REG_GAIN, 16'hFFFF);
    write_reg(REG_MAX_DUTY, 16'h7FFF);
    cfg_we <= 1'b0;
    send_item(CMD_TICK, '0, '0, 12'd4094);
    // held duty repeats on a target change
    send_item(CMD_SET_TARGET, 16'sh7FFF, '0, '0);
    send_item(CMD_TICK, 16'shFFFF, 24'sh800000, 12'hFFF);
    send_item(CMD_TICK, '0, 24'sh7FFFFF, 12'hFFF);
    send_item(CMD_TICK, '0, 24'sh800000, 12'd0);
    send_item(CMD_TICK, '0, 24'sd420, 12'd0);

    settle();
    write_reg(REG_GAIN, 16'd213);
    write_reg(REG_MAX_DUTY, 16'd14746);
    write_reg(REG_DEADBAND, 16'd3);
    cfg_we <= 1'b0;
    send_item(CMD_TICK, '0, 24'sd423, 12'd0);
    send_item(CMD_TICK, '0, 24'sd424, 12'd0);
    send_item(CMD_TICK, '0, 24'sd416, 12'd0);
    send_item(CMD_SET_TARGET, -16'sd500, '0, '0);
    send_item(CMD_TICK, '0, -24'sd110, 12'd0);
    send_item(CMD_TICK, '0, -24'sd260, 12'hFFF);

    // wide span; gain, maximum duty and seek duty at the top of their range
    settle();
    write_reg(REG_GAIN, 16'hFFFF);
    write_reg(REG_MAX_DUTY, 16'h7FFF);
    write_reg(REG_SEEK_DUTY, 16'h7FFF);
    write_reg(REG_SWITCH_THRESHOLD, 16'h0000);
    write_reg(REG_CENTER_POSITION, 16'h8000);
    write_reg(REG_LEFT_LIMIT, 16'h8000);
    write_reg(REG_RIGHT_LIMIT, 16'h7FFF);
    write_reg(REG_DEADBAND, 16'h0000);
    cfg_we <= 1'b0;
    run_random(60, 1'b1);

    // reversed limits, zero gain and saturation, full deadband
    settle();
    write_reg(REG_GAIN, 16'h0000);
    write_reg(REG_MAX_DUTY, 16'h0000);
    write_reg(REG_SEEK_DUTY, 16'h0000);
    write_reg(REG_SWITCH_THRESHOLD, 16'h0FFF);
    write_reg(REG_CENTER_POSITION, 16'h7FFF);
    write_reg(REG_LEFT_LIMIT, 16'h7FFF);
    write_reg(REG_RIGHT_LIMIT, 16'h8000);
    write_reg(REG_DEADBAND, 16'hFFFF);
    cfg_we <= 1'b0;
    run_random(40, 1'b1);

    for (int k = 0; k < 4; k++) begin
      settle();
      random_config();
      run_random(100, k < 3);
    end

    in_valid <= 1'b0;
    gaps_on = 1'b0;
    @(posedge clk);
    waited = 0;
    while (results_due != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (failures == 0 && results_due == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
